### hw/rtl/rc4_stream_cipher_defines.svh
// Assertion helpers shared by the checker files.
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RC4_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rc4_pkg.sv
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int SBOX_DEPTH = 256;
    localparam int SBOX_AW    = 8;
    localparam int KEY_WORD_W = 64;
    localparam int KEY_LEN_W  = 5;
    localparam int CFG_ADDR_W = 2;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd8;
    localparam logic [SBOX_AW-1:0]   SBOX_LAST     = 8'd255;

    // register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LEN  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_KSA_RD_N,
        ST_KSA_RD_J,
        ST_KSA_WR_N,
        ST_KSA_WR_J,
        ST_GEN_RD_I,
        ST_GEN_RD_J,
        ST_GEN_WR_I,
        ST_GEN_WR_J,
        ST_GEN_RD_K,
        ST_GEN_OUT
    } rc4_state_t;

    typedef struct packed {
        logic               we;
        logic [SBOX_AW-1:0] waddr;
        logic [BYTE_W-1:0]  wdata;
        logic               re;
        logic [SBOX_AW-1:0] raddr;
    } sbox_req_t;

endpackage

### hw/rtl/rc4_sbox_ram.sv
`timescale 1ns / 1ps

// 256 x 8 permutation store, one write and one registered read per cycle.
module rc4_sbox_ram
    import rc4_pkg::*;
(
    input  logic              aclk,
    input  sbox_req_t         req,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [SBOX_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/rc4_alu.sv
`timescale 1ns / 1ps

// Shared mod-256 three-operand adder.
module rc4_alu
    import rc4_pkg::*;
(
    input  logic [BYTE_W-1:0] op_a,
    input  logic [BYTE_W-1:0] op_b,
    input  logic [BYTE_W-1:0] op_c,
    output logic [BYTE_W-1:0] sum
);

    assign sum = op_a + op_b + op_c;

endmodule

### hw/rtl/rc4_engine.sv
`timescale 1ns / 1ps

// Sequencer for key schedule and generator, around one adder and one RAM port.
module rc4_engine
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [2*KEY_WORD_W-1:0] key_vec,
    input  logic [KEY_LEN_W-1:0]   key_len,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [BYTE_W-1:0]      s_data_in,
    input  logic                   s_msg_start,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [BYTE_W-1:0]      m_data_out
);

    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int LEN_W  = KIDX_W + 1;

    rc4_state_t state_reg, state_next;

    logic [SBOX_AW-1:0] n_reg;
    logic [SBOX_AW-1:0] i_reg;
    logic [SBOX_AW-1:0] j_reg;
    logic [BYTE_W-1:0]  si_reg;
    logic [BYTE_W-1:0]  sj_reg;
    logic [BYTE_W-1:0]  din_reg;
    logic [KIDX_W-1:0]  kpos_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               keyed_reg;
    logic               m_valid_reg;
    logic [BYTE_W-1:0]  m_data_reg;

    sbox_req_t         ram_req;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] alu_a, alu_b, alu_c, alu_sum;
    logic [BYTE_W-1:0] key_byte;
    logic [LEN_W-1:0]  len_eff;
    logic [LEN_W-1:0]  kpos_inc;
    logic              out_free;
    logic              n_last;

    rc4_sbox_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    rc4_alu u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .op_c (alu_c),
        .sum  (alu_sum)
    );

    assign key_byte = key_vec[{kpos_reg, 3'b000} +: BYTE_W];
    assign kpos_inc = {1'b0, kpos_reg} + LEN_W'(1);
    assign out_free = !m_valid_reg || m_ready;
    assign n_last   = (n_reg == SBOX_LAST);

    // zero length acts as one, oversize saturates
    always_comb begin
        if (key_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (key_len > KEY_LEN_W'(MAX_KEY_BYTES)) begin
            len_eff = LEN_W'(MAX_KEY_BYTES);
        end else begin
            len_eff = LEN_W'(key_len);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_msg_start || !keyed_reg) ? ST_INIT : ST_GEN_RD_I;
                end
            end
            ST_INIT:     state_next = n_last ? ST_KSA_RD_N : ST_INIT;
            ST_KSA_RD_N: state_next = ST_KSA_RD_J;
            ST_KSA_RD_J: state_next = ST_KSA_WR_N;
            ST_KSA_WR_N: state_next = ST_KSA_WR_J;
            ST_KSA_WR_J: state_next = n_last ? ST_GEN_RD_I : ST_KSA_RD_N;
            ST_GEN_RD_I: state_next = ST_GEN_RD_J;
            ST_GEN_RD_J: state_next = ST_GEN_WR_I;
            ST_GEN_WR_I: state_next = ST_GEN_WR_J;
            ST_GEN_WR_J: state_next = ST_GEN_RD_K;
            ST_GEN_RD_K: state_next = ST_GEN_OUT;
            ST_GEN_OUT:  state_next = out_free ? ST_IDLE : ST_GEN_OUT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // RAM port and adder operand selection
    always_comb begin
        ram_req = '0;
        alu_a   = '0;
        alu_b   = '0;
        alu_c   = '0;
        unique case (state_reg)
            ST_INIT: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = n_reg;
                ram_req.wdata = n_reg;
            end
            ST_KSA_RD_N: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = n_reg;
            end
            ST_KSA_RD_J: begin
                alu_a         = j_reg;
                alu_b         = key_byte;
                alu_c         = ram_rdata;
                ram_req.re    = 1'b1;
                ram_req.raddr = alu_sum;
            end
            ST_KSA_WR_N: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = n_reg;
                ram_req.wdata = ram_rdata;
            end
            ST_KSA_WR_J: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = j_reg;
                ram_req.wdata = si_reg;
            end
            ST_GEN_RD_I: begin
                alu_a         = i_reg;
                alu_b         = BYTE_W'(1);
                ram_req.re    = 1'b1;
                ram_req.raddr = alu_sum;
            end
            ST_GEN_RD_J: begin
                alu_a         = j_reg;
                alu_b         = ram_rdata;
                ram_req.re    = 1'b1;
                ram_req.raddr = alu_sum;
            end
            ST_GEN_WR_I: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = i_reg;
                ram_req.wdata = ram_rdata;
            end
            ST_GEN_WR_J: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = j_reg;
                ram_req.wdata = si_reg;
            end
            ST_GEN_RD_K: begin
                alu_a         = si_reg;
                alu_b         = sj_reg;
                ram_req.re    = 1'b1;
                ram_req.raddr = alu_sum;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            n_reg       <= '0;
            kpos_reg    <= '0;
            keyed_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // load a new result, else hold until taken
            m_valid_reg <= ((state_reg == ST_GEN_OUT) && out_free) ||
                           (m_valid_reg && !m_ready);
            unique case (state_reg)
                ST_IDLE: begin
                    n_reg    <= '0;
                    kpos_reg <= '0;
                    if (s_valid && (s_msg_start || !keyed_reg)) begin
                        j_reg <= '0;
                    end
                end
                ST_INIT: n_reg <= n_reg + SBOX_AW'(1);
                ST_KSA_RD_J: j_reg <= alu_sum;
                ST_KSA_WR_J: begin
                    n_reg    <= n_reg + SBOX_AW'(1);
                    kpos_reg <= (kpos_inc == len_reg) ? '0 : kpos_inc[KIDX_W-1:0];
                    if (n_last) begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        keyed_reg <= 1'b1;
                    end
                end
                ST_GEN_RD_I: i_reg <= alu_sum;
                ST_GEN_RD_J: j_reg <= alu_sum;
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                din_reg <= s_data_in;
                len_reg <= len_eff;
            end
            ST_KSA_RD_J: si_reg <= ram_rdata;
            ST_GEN_RD_J: si_reg <= ram_rdata;
            ST_GEN_WR_I: sj_reg <= ram_rdata;
            ST_GEN_OUT: begin
                if (out_free) begin
                    m_data_reg <= din_reg ^ ram_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_data_out = m_data_reg;

endmodule

### hw/rtl/rc4_stream_cipher.sv
`timescale 1ns / 1ps

// RC4 byte cipher: each beat on s_ carries one byte and a message-start flag
// and yields exactly one byte on m_ (input XOR keystream). From idle to idle,
// the generator runs six steps of the shared adder and the single permutation
// RAM port (read S[i], read S[j], two swap writes, keystream read, output); the
// output step waits while an earlier result is not yet taken. A beat with
// s_msg_start high, or the first beat after reset, first runs the key schedule:
// it loads the identity permutation, then does 256 swaps (read S[n], read S[j],
// two swap writes) before that byte starts. s_ready is low from accept until
// the result is registered; a waiting result does not block the next accept.
// Config writes (cfg_ready is always high) should land only while idle; key
// changes apply at the next key schedule. Index 0 is key_low, 1 key_high, 2
// key_len (zero acts as one, above MAX_KEY_BYTES saturates); index 3 is ignored.
module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_data_in,
    input  logic                  s_msg_start,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BYTE_W-1:0]     m_data_out,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [KEY_WORD_W-1:0] cfg_data
);

    logic [KEY_WORD_W-1:0] key_low_reg;
    logic [KEY_WORD_W-1:0] key_high_reg;
    logic [KEY_LEN_W-1:0]  key_len_reg;

    // config beats are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= KEY_LEN_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LEN:  key_len_reg  <= cfg_data[KEY_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rc4_engine #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .key_vec     ({key_high_reg, key_low_reg}),
        .key_len     (key_len_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_in   (s_data_in),
        .s_msg_start (s_msg_start),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_out  (m_data_out)
    );

endmodule

### hw/rtl/rc4_checker.sv
`timescale 1ns / 1ps
`include "rc4_stream_cipher_defines.svh"

module rc4_checker
    import rc4_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [BYTE_W-1:0] m_data_out
);

    `RC4_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data_out), "result beat dropped or changed while stalled")
    `RC4_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "input accepted while a byte is in flight")
    `RC4_ASSERT_NEXT(a_idle_stays_ready, s_ready && !s_valid, s_ready, "idle block dropped ready without a beat")
    `RC4_ASSERT_NOW(a_result_frees_input, $rose(m_valid), s_ready, "result appeared without the engine returning idle")

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_data_out (m_data_out)
);
